>>> hw/rtl/grid_raycast_column_defines.svh
// Assertion macros used by the grid ray caster RTL (grc_back).
// Expects clk and arst_n in the scope of every use.
`ifndef GRID_RAYCAST_COLUMN_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_DEFINES_SVH
`ifndef ASSERT_OFF
`define GRC_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define GRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define GRC_ASSERT(lbl, expr)
`define GRC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/grc_pkg.sv
// Types and constants of the grid ray caster.
// No dependencies; imported by grc_front, grc_div, grc_back and the top level.
package grc_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [1:0] KIND_CEIL  = 2'd0;
	localparam logic [1:0] KIND_WALL  = 2'd1;
	localparam logic [1:0] KIND_FLOOR = 2'd2;

	localparam logic [2:0] CFG_CEIL_COLOR  = 3'd0;
	localparam logic [2:0] CFG_FLOOR_COLOR = 3'd1;
	localparam logic [2:0] CFG_VIEW_X      = 3'd2;
	localparam logic [2:0] CFG_VIEW_Y      = 3'd3;
	localparam logic [2:0] CFG_DIST_PLANE  = 3'd4;
	localparam logic [2:0] CFG_SCREEN_H    = 3'd5;

	localparam logic [31:0] WALL_COLOR = 32'hFFFF_0000;

	localparam int DIST_W = 48;
	localparam int NUM_W  = 64;

	typedef struct packed {
		logic               cast;
		logic [11:0]        cell_index;
		logic [15:0]        cell_value;
		logic [10:0]        column;
		logic [21:0]        pos_x;
		logic [21:0]        pos_y;
		logic signed [15:0] ray_x;
		logic signed [15:0] ray_y;
	} grc_item_t;

	typedef struct packed {
		logic [31:0]        ceiling_color;
		logic [31:0]        floor_color;
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic [15:0]        dist_to_plane;
		logic [11:0]        screen_height;
	} grc_cfg_t;

endpackage

>>> hw/rtl/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/grc_fifo.sv
// Short queue between the front and back parts of the ray caster.
// No dependencies.
module grc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [IW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == IW'(DEPTH - 1)) ? '0 : wp_q + IW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == IW'(DEPTH - 1)) ? '0 : rp_q + IW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

>>> hw/rtl/grc_front.sv
// Input side: unpacks stream words, classifies them and queues work.
// Depends on grc_pkg and grc_fifo.
module grc_front
	import grc_pkg::*;
#(
	parameter int MAP_DIM = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [119:0] s_tdata,
	input  logic       s_tuser,
	input  logic       pop,
	output grc_item_t  item,
	output logic       item_valid
);
	grc_item_t in_item;
	logic      full, empty, keep;

	always_comb begin
		in_item.cast       = (s_tuser == OP_CAST);
		in_item.cell_index = s_tdata[11:0];
		in_item.cell_value = s_tdata[27:12];
		in_item.column     = s_tdata[38:28];
		in_item.pos_x      = s_tdata[60:39];
		in_item.pos_y      = s_tdata[82:61];
		in_item.ray_x      = s_tdata[98:83];
		in_item.ray_y      = s_tdata[114:99];
	end

	// drop map writes beyond the map
	assign keep     = in_item.cast || (32'(in_item.cell_index) < 32'(MAP_DIM * MAP_DIM));
	assign s_tready = !full;

	grc_fifo #(.WIDTH($bits(grc_item_t)), .DEPTH(2)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (s_tvalid && keep),
		.wdata (in_item),
		.pop   (pop),
		.rdata (item),
		.full  (full),
		.empty (empty)
	);

	assign item_valid = !empty;
endmodule

>>> hw/rtl/grc_div.sv
// Restoring divider, one quotient bit per cycle.
// Dividend arrives left-aligned; nbits sets the number of steps.
module grc_div
	import grc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DIST_W-1:0] den,
	input  logic [6:0]        nbits,
	output logic              busy,
	output logic              done,
	output logic [NUM_W-1:0]  quo
);
	logic [NUM_W-1:0]  num_q, quo_q;
	logic [DIST_W-1:0] den_q, rem_q;
	logic [6:0]        cnt_q;
	logic              busy_q, done_q;
	logic [DIST_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? DIST_W'(trial - {1'b0, den_q}) : DIST_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule

>>> hw/rtl/grc_back.sv
// Execution side: map writes, DDA walk, distance correction, wall height and
// row runs. Depends on grc_pkg, grc_ram, grc_div and the assertion macros.
`include "grid_raycast_column_defines.svh"
module grc_back
	import grc_pkg::*;
#(
	parameter int MAP_DIM  = 64,
	parameter int MAX_ROWS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  grc_cfg_t    cfg,
	input  grc_item_t   item,
	input  logic        item_valid,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	localparam int AW         = $clog2(MAP_DIM * MAP_DIM);
	localparam int CW         = $clog2(MAP_DIM + 1) + 1;
	localparam int WALK_LIMIT = 2 * MAP_DIM + 2;
	localparam int NW         = $clog2(WALK_LIMIT + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DDX   = 4'd1;
	localparam logic [3:0] ST_DSX   = 4'd2;
	localparam logic [3:0] ST_DDY   = 4'd3;
	localparam logic [3:0] ST_DSY   = 4'd4;
	localparam logic [3:0] ST_WALK  = 4'd5;
	localparam logic [3:0] ST_CHK   = 4'd6;
	localparam logic [3:0] ST_DOT1  = 4'd7;
	localparam logic [3:0] ST_DOT2  = 4'd8;
	localparam logic [3:0] ST_MULLO = 4'd9;
	localparam logic [3:0] ST_MULHI = 4'd10;
	localparam logic [3:0] ST_HDIV  = 4'd11;
	localparam logic [3:0] ST_SPAN  = 4'd12;
	localparam logic [3:0] ST_EMIT  = 4'd13;

	logic [3:0]        state_q;
	logic              div_wait_q, hit_q, tookx_q;
	logic              xv_q, yv_q, xneg_q, yneg_q;
	logic [1:0]        run_q;
	logic [NW-1:0]     n_q;
	logic [10:0]       col_q, mid_q;
	logic [11:0]       h_q, s_q, e_q;
	logic signed [15:0] rx_q, ry_q;
	logic [15:0]       ax_q, ay_q;
	logic [16:0]       frx_q, fry_q, d15_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic [DIST_W-1:0] sdx_q, sdy_q, ddx_q, ddy_q, dist_q, corr_q;
	logic signed [31:0] prod_q;
	logic [40:0]       plo_q;
	logic [53:0]       height_q;

	logic              o_valid_q, o_last_q;
	logic [1:0]        o_kind_q;
	logic [10:0]       o_col_q;
	logic [11:0]       o_start_q, o_end_q;
	logic [31:0]       o_color_q;

	logic              div_start, div_busy, div_done;
	logic [NUM_W-1:0]  div_num, div_quo;
	logic [DIST_W-1:0] div_den;
	logic [6:0]        div_nbits;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [15:0]       ram_rdata;

	logic              takex;
	logic signed [CW-1:0] ncx, ncy;
	logic              out_of_map;

	logic [11:0]       h_in;
	logic              eye_in, ray_zero;
	logic [15:0]       ax_in, ay_in;
	logic signed [32:0] dot;
	logic [40:0]       phi;
	logic [65:0]       psum;
	logic [52:0]       half;
	logic [26:0]       m16;
	logic [53:0]       esum;
	logic [11:0]       s_raw, e_raw;

	logic              load_out;
	logic [1:0]        r_kind;
	logic [11:0]       r_start, r_end;
	logic [31:0]       r_color;
	logic              r_last;

	grc_ram #(.WIDTH(16), .DEPTH(MAP_DIM * MAP_DIM)) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(item.cell_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	grc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.nbits (div_nbits),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign pop       = (state_q == ST_IDLE) && item_valid;
	assign ram_we    = pop && !item.cast;
	assign ram_waddr = AW'(item.cell_index);

	assign h_in     = ({1'b0, cfg.screen_height} < 13'(MAX_ROWS)) ? cfg.screen_height
	                                                              : 12'(MAX_ROWS);
	assign eye_in   = (32'(item.pos_x[21:16]) < 32'(MAP_DIM))
	               && (32'(item.pos_y[21:16]) < 32'(MAP_DIM));
	assign ray_zero = (item.ray_x == '0) && (item.ray_y == '0);
	assign ax_in    = item.ray_x[15] ? 16'(~item.ray_x + 16'sd1) : item.ray_x;
	assign ay_in    = item.ray_y[15] ? 16'(~item.ray_y + 16'sd1) : item.ray_y;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_nbits = 7'd32;
		unique case (state_q)
			ST_DDX: begin
				div_start = !div_wait_q;
				div_num   = {1'b1, 63'b0};
				div_den   = DIST_W'(ax_q);
			end
			ST_DSX: begin
				div_start = !div_wait_q;
				div_num   = {frx_q, 47'b0};
				div_den   = DIST_W'(ax_q);
			end
			ST_DDY: begin
				div_start = !div_wait_q;
				div_num   = {1'b1, 63'b0};
				div_den   = DIST_W'(ay_q);
			end
			ST_DSY: begin
				div_start = !div_wait_q;
				div_num   = {fry_q, 47'b0};
				div_den   = DIST_W'(ay_q);
			end
			ST_HDIV: begin
				div_start = !div_wait_q && (corr_q != '0);
				div_num   = {cfg.dist_to_plane, 48'b0};
				div_den   = corr_q;
				div_nbits = 7'd54;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign takex = xv_q && (!yv_q || (sdx_q <= sdy_q));
	assign ncx   = takex ? (xneg_q ? cx_q - CW'(1) : cx_q + CW'(1)) : cx_q;
	assign ncy   = takex ? cy_q : (yneg_q ? cy_q - CW'(1) : cy_q + CW'(1));
	assign out_of_map = ncx[CW-1] || ncy[CW-1]
	                 || (ncx >= $signed(CW'(MAP_DIM))) || (ncy >= $signed(CW'(MAP_DIM)));
	assign ram_raddr  = AW'(AW'(ncy[CW-2:0]) * AW'(MAP_DIM) + AW'(ncx[CW-2:0]));

	assign dot  = 33'(prod_q) + 33'(ry_q * cfg.view_dir_y);
	assign phi  = dist_q[47:24] * d15_q;
	assign psum = {25'b0, phi} << 24;

	assign half  = height_q[53:1];
	assign m16   = {mid_q, 16'b0};
	assign esum  = 54'(half) + 54'(m16);
	assign s_raw = (53'(m16) > half) ? 12'((53'(m16) - half) >> 16) : 12'd0;
	assign e_raw = (esum[53:16] > 38'(h_q)) ? h_q : 12'(esum[53:16]);

	always_comb begin
		r_kind  = KIND_CEIL;
		r_start = '0;
		r_end   = s_q;
		r_color = cfg.ceiling_color;
		r_last  = 1'b0;
		unique case (run_q)
			2'd0: begin
				r_end = hit_q ? s_q : 12'(mid_q);
			end
			2'd1: begin
				if (hit_q) begin
					r_kind  = KIND_WALL;
					r_start = s_q;
					r_end   = e_q;
					r_color = WALL_COLOR;
				end else begin
					r_kind  = KIND_FLOOR;
					r_start = 12'(mid_q);
					r_end   = h_q;
					r_color = cfg.floor_color;
					r_last  = 1'b1;
				end
			end
			default: begin
				r_kind  = KIND_FLOOR;
				r_start = e_q;
				r_end   = h_q;
				r_color = cfg.floor_color;
				r_last  = 1'b1;
			end
		endcase
	end

	assign load_out = (state_q == ST_EMIT) && (!o_valid_q || m_tready);

	always_ff @(posedge clk) begin
		if (pop && item.cast) begin
			col_q  <= item.column;
			rx_q   <= item.ray_x;
			ry_q   <= item.ray_y;
			ax_q   <= ax_in;
			ay_q   <= ay_in;
			xneg_q <= item.ray_x[15];
			yneg_q <= !item.ray_y[15];
			frx_q  <= item.ray_x[15] ? {1'b0, item.pos_x[15:0]}
			                         : 17'h10000 - {1'b0, item.pos_x[15:0]};
			fry_q  <= item.ray_y[15] ? 17'h10000 - {1'b0, item.pos_y[15:0]}
			                         : {1'b0, item.pos_y[15:0]};
			cx_q   <= CW'(item.pos_x[21:16]);
			cy_q   <= CW'(item.pos_y[21:16]);
			h_q    <= h_in;
			mid_q  <= h_in[11:1];
		end
		if (div_done) begin
			unique case (state_q)
				ST_DDX:  ddx_q    <= DIST_W'(div_quo[31:0]);
				ST_DSX:  sdx_q    <= DIST_W'(div_quo[31:0]);
				ST_DDY:  ddy_q    <= DIST_W'(div_quo[31:0]);
				ST_DSY:  sdy_q    <= DIST_W'(div_quo[31:0]);
				default: height_q <= div_quo[53:0];
			endcase
		end
		if (state_q == ST_WALK) begin
			cx_q    <= ncx;
			cy_q    <= ncy;
			tookx_q <= takex;
		end
		if (state_q == ST_CHK) begin
			dist_q <= tookx_q ? sdx_q : sdy_q;
			if (ram_rdata == '0) begin
				if (tookx_q) begin
					sdx_q <= sdx_q + ddx_q;
				end else begin
					sdy_q <= sdy_q + ddy_q;
				end
			end
		end
		if (state_q == ST_DOT1) begin
			prod_q <= rx_q * cfg.view_dir_x;
		end
		if (state_q == ST_DOT2) begin
			d15_q <= (dot > 33'sd0) ? dot[31:15] : 17'd0;
		end
		if (state_q == ST_MULLO) begin
			plo_q <= dist_q[23:0] * d15_q;
		end
		if (state_q == ST_MULHI) begin
			corr_q <= DIST_W'((psum + 66'(plo_q)) >> 15);
		end
		if (state_q == ST_SPAN) begin
			s_q <= (s_raw > h_q) ? h_q : s_raw;
			e_q <= e_raw;
		end
		if (load_out) begin
			o_col_q   <= col_q;
			o_kind_q  <= r_kind;
			o_start_q <= r_start;
			o_end_q   <= r_end;
			o_color_q <= r_color;
			o_last_q  <= r_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			div_wait_q <= 1'b0;
			hit_q      <= 1'b0;
			xv_q       <= 1'b0;
			yv_q       <= 1'b0;
			n_q        <= '0;
			run_q      <= '0;
			o_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
			if (div_done) begin
				div_wait_q <= 1'b0;
			end else if (div_start) begin
				div_wait_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && item.cast) begin
						xv_q  <= (item.ray_x != '0);
						yv_q  <= (item.ray_y != '0);
						hit_q <= 1'b0;
						n_q   <= '0;
						run_q <= '0;
						if (ray_zero || !eye_in) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= (item.ray_x != '0) ? ST_DDX : ST_DDY;
						end
					end
				end
				ST_DDX: begin
					if (div_done) state_q <= ST_DSX;
				end
				ST_DSX: begin
					if (div_done) state_q <= yv_q ? ST_DDY : ST_WALK;
				end
				ST_DDY: begin
					if (div_done) state_q <= ST_DSY;
				end
				ST_DSY: begin
					if (div_done) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (n_q == NW'(WALK_LIMIT) || out_of_map) begin
						state_q <= ST_EMIT;
					end else begin
						n_q     <= n_q + NW'(1);
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= (ram_rdata != '0) ? ST_DOT1 : ST_WALK;
				end
				ST_DOT1: state_q <= ST_DOT2;
				ST_DOT2: state_q <= ST_MULLO;
				ST_MULLO: state_q <= ST_MULHI;
				ST_MULHI: begin
					state_q <= ST_HDIV;
				end
				ST_HDIV: begin
					if (corr_q == '0) begin
						state_q <= ST_EMIT;
					end else if (div_done) begin
						hit_q   <= 1'b1;
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (load_out) begin
						run_q <= run_q + 2'd1;
						if (r_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'b0, o_color_q, o_end_q, o_start_q, o_col_q};

	`GRC_ASSERT_IMP(a_run_order, o_valid_q, o_start_q <= o_end_q)
	`GRC_ASSERT_IMP(a_div_free, div_start, !div_busy)
	`GRC_ASSERT_IMP(a_walk_axis, state_q == ST_WALK, xv_q || yv_q)
endmodule

>>> hw/rtl/grid_raycast_column.sv
// Top level of the grid ray caster: configuration registers and the
// front/back split. Depends on grc_pkg, grc_front and grc_back.
//
// A cast runs the step and first-boundary divisions (one bit a cycle in the
// shared divider), reads the map RAM for each visited cell, up to
// 2*MAP_DIM+2 cells, then the view-direction correction and the wall height
// division, and emits its runs; an early hit ends the walk sooner. A
// two-word queue holds arriving words while a cast is in progress.
// Wall runs are red; a cast reads the configuration registers while it runs,
// so write them only while no cast is in progress.
module grid_raycast_column
	import grc_pkg::*;
#(
	parameter int MAP_DIM  = 64,
	parameter int MAX_ROWS = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cell_index, cell_value, column, pos_x, pos_y, ray_x, ray_y
	input  logic [119:0] s_tdata,
	// opcode
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_column, run_start, run_end, run_color
	output logic [71:0]  m_tdata,
	// run_kind
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	grc_cfg_t  cfg_q;
	grc_item_t item;
	logic      item_valid, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ceiling_color <= 32'hFFAA_AAAA;
			cfg_q.floor_color   <= 32'hFF55_5555;
			cfg_q.view_dir_x    <= 16'sd0;
			cfg_q.view_dir_y    <= 16'sd32767;
			cfg_q.dist_to_plane <= 16'd256;
			cfg_q.screen_height <= 12'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CEIL_COLOR:  cfg_q.ceiling_color <= cfg_data;
				CFG_FLOOR_COLOR: cfg_q.floor_color   <= cfg_data;
				CFG_VIEW_X:      cfg_q.view_dir_x    <= cfg_data[15:0];
				CFG_VIEW_Y:      cfg_q.view_dir_y    <= cfg_data[15:0];
				CFG_DIST_PLANE:  cfg_q.dist_to_plane <= cfg_data[15:0];
				CFG_SCREEN_H:    cfg_q.screen_height <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	grc_front #(.MAP_DIM(MAP_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.pop       (pop),
		.item      (item),
		.item_valid(item_valid)
	);

	grc_back #(.MAP_DIM(MAP_DIM), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.item_valid(item_valid),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);
endmodule
